@@ rtl/upc_pkg.sv @@
`default_nettype none

package upc_pkg;

  // field widths and results per input item
  localparam int ByteW = 8;
  localparam int NibW  = 4;
  localparam int MaxRes = 3;

  // character codes
  localparam logic [ByteW-1:0] ChPlus    = 8'h2B;
  localparam logic [ByteW-1:0] ChPercent = 8'h25;
  localparam logic [ByteW-1:0] ChSpace   = 8'h20;
  localparam logic [ByteW-1:0] ChMinus   = 8'h2D;
  localparam logic [ByteW-1:0] ChUnder   = 8'h5F;
  localparam logic [ByteW-1:0] ChDot     = 8'h2E;
  localparam logic [ByteW-1:0] ChTilde   = 8'h7E;
  localparam logic [ByteW-1:0] ChUpperA  = 8'h41;
  localparam logic [ByteW-1:0] ChUpperZ  = 8'h5A;
  localparam logic [ByteW-1:0] ChLowerA  = 8'h61;
  localparam logic [ByteW-1:0] ChLowerZ  = 8'h7A;
  localparam logic [ByteW-1:0] ChZero    = 8'h30;
  localparam logic [ByteW-1:0] ChNine    = 8'h39;

  // offsets for hex digit conversion
  localparam logic [ByteW-1:0] HexLetterOfs = 8'd55;
  localparam logic [ByteW-1:0] DigitOfs     = 8'd48;
  localparam logic [ByteW-1:0] LowerOfs     = 8'd87;

  // escape tracking
  typedef enum logic [1:0] {
    PH_NONE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_t;

  // one result beat
  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             run_last;
    logic             message_end;
    logic             escape_cut;
  } res_t;

  // all results of one input item, entry 0 goes out first
  typedef struct packed {
    logic [1:0]             count;
    res_t [MaxRes-1:0]      res;
  } step_t;

  // nibble to uppercase hex character
  function automatic logic [ByteW-1:0] nibble_char(input logic [NibW-1:0] n);
    logic [ByteW-1:0] w;
    w = {{(ByteW-NibW){1'b0}}, n};
    return (n > 4'd9) ? (w + HexLetterOfs) : (w + DigitOfs);
  endfunction

  // character to digit, no validation
  function automatic logic [ByteW-1:0] char_digit(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] d;
    if (c >= ChUpperA && c <= ChUpperZ) begin
      d = c - HexLetterOfs;
    end else if (c >= ChLowerA && c <= ChLowerZ) begin
      d = c - LowerOfs;
    end else begin
      d = c - DigitOfs;
    end
    return d;
  endfunction

  // unreserved characters that pass through encoding
  function automatic logic plain_char(input logic [ByteW-1:0] c);
    return (c >= ChUpperA && c <= ChUpperZ) || (c >= ChLowerA && c <= ChLowerZ) ||
           (c >= ChZero && c <= ChNine) || c == ChMinus || c == ChUnder ||
           c == ChDot || c == ChTilde;
  endfunction

endpackage

`default_nettype wire

@@ rtl/upc_stream_if.sv @@
`default_nettype none

// input byte channel
interface upc_in_if;
  import upc_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;
  logic             message_last;

  modport source(output valid, output in_byte, output message_last, input ready);
  modport sink(input valid, input in_byte, input message_last, output ready);
endinterface

// result byte channel
interface upc_out_if;
  import upc_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             run_last;
  logic             message_end;
  logic             escape_cut;

  modport source(output valid, output out_byte, output run_last, output message_end,
                 output escape_cut, input ready);
  modport sink(input valid, input out_byte, input run_last, input message_end,
               input escape_cut, output ready);
endinterface

`default_nettype wire

@@ rtl/upc_step.sv @@
`default_nettype none

module upc_step (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      fire,
  input  wire logic                      decode_mode,
  input  wire logic [upc_pkg::ByteW-1:0] cur_byte,
  input  wire logic                      cur_last,
  output upc_pkg::step_t                 step
);
  import upc_pkg::*;

  phase_t          phase, phase_next;
  logic [NibW-1:0] high_digit, high_digit_next;
  logic [ByteW-1:0] digit;
  logic [ByteW-1:0] joined;
  res_t            cut_res;

  assign digit   = char_digit(cur_byte);
  assign joined  = {high_digit, {NibW{1'b0}}} + digit;
  assign cut_res = '{out_byte: '0, run_last: 1'b1, message_end: 1'b1, escape_cut: 1'b1};

  // results and escape state for the held byte
  always_comb begin
    step            = '0;
    phase_next      = phase;
    high_digit_next = high_digit;
    if (!decode_mode) begin
      phase_next      = PH_NONE;
      high_digit_next = '0;
      if (plain_char(cur_byte)) begin
        step.count  = 2'd1;
        step.res[0] = '{out_byte: cur_byte, run_last: 1'b1, message_end: cur_last,
                        escape_cut: 1'b0};
      end else if (cur_byte == ChSpace) begin
        step.count  = 2'd1;
        step.res[0] = '{out_byte: ChPlus, run_last: 1'b1, message_end: cur_last,
                        escape_cut: 1'b0};
      end else begin
        step.count  = 2'd3;
        step.res[0] = '{out_byte: ChPercent, run_last: 1'b0, message_end: 1'b0,
                        escape_cut: 1'b0};
        step.res[1] = '{out_byte: nibble_char(cur_byte[ByteW-1:NibW]), run_last: 1'b0,
                        message_end: 1'b0, escape_cut: 1'b0};
        step.res[2] = '{out_byte: nibble_char(cur_byte[NibW-1:0]), run_last: 1'b1,
                        message_end: cur_last, escape_cut: 1'b0};
      end
    end else begin
      case (phase)
        PH_HIGH: begin
          if (cur_last) begin
            phase_next      = PH_NONE;
            high_digit_next = '0;
            step.count      = 2'd1;
            step.res[0]     = cut_res;
          end else begin
            high_digit_next = digit[NibW-1:0];
            phase_next      = PH_LOW;
          end
        end
        PH_LOW: begin
          phase_next      = PH_NONE;
          high_digit_next = '0;
          step.count      = 2'd1;
          step.res[0]     = '{out_byte: joined, run_last: 1'b1, message_end: cur_last,
                              escape_cut: 1'b0};
        end
        default: begin
          phase_next = PH_NONE;
          if (cur_byte == ChPercent) begin
            if (cur_last) begin
              high_digit_next = '0;
              step.count      = 2'd1;
              step.res[0]     = cut_res;
            end else begin
              phase_next = PH_HIGH;
            end
          end else if (cur_byte == ChPlus) begin
            step.count  = 2'd1;
            step.res[0] = '{out_byte: ChSpace, run_last: 1'b1, message_end: cur_last,
                            escape_cut: 1'b0};
          end else begin
            step.count  = 2'd1;
            step.res[0] = '{out_byte: cur_byte, run_last: 1'b1, message_end: cur_last,
                            escape_cut: 1'b0};
          end
        end
      endcase
    end
  end

  // escape state advances once per processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_NONE;
      high_digit <= '0;
    end else if (fire) begin
      phase      <= phase_next;
      high_digit <= high_digit_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/upc_outbuf.sv @@
`default_nettype none

module upc_outbuf (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   load,
  input  wire upc_pkg::step_t step,
  output logic        can_load,
  upc_out_if.source   out
);
  import upc_pkg::*;

  res_t [MaxRes-1:0] slots;
  logic [1:0]        cnt;
  logic              pop;

  assign pop      = out.valid && out.ready;
  assign can_load = (cnt == 2'd0) || (cnt == 2'd1 && out.ready);

  // head slot drives the result channel
  assign out.valid       = (cnt != 2'd0);
  assign out.out_byte    = slots[0].out_byte;
  assign out.run_last    = slots[0].run_last;
  assign out.message_end = slots[0].message_end;
  assign out.escape_cut  = slots[0].escape_cut;

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= step.count;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  // result slots, shift toward the head on each beat
  always_ff @(posedge clk) begin
    if (load) begin
      slots <= step.res;
    end else if (pop) begin
      slots[0] <= slots[1];
      slots[1] <= slots[2];
    end
  end

endmodule

`default_nettype wire

@@ rtl/url_percent_codec_unit.sv @@
`default_nettype none

// URL percent codec (form-urlencoded flavor) on a byte stream. cfg_wr_en with
// cfg_wr_data selects encode (0) or decode (1); change it only between messages
// while the block is idle. An input beat is registered, then the codec logic
// turns it into zero to three result bytes held in a small result buffer that
// drives the output one beat per cycle while out.ready is high. Encoding an
// escaped byte yields three result bytes, every other byte yields one; a decode
// '%' or high hex character yields nothing. An input byte moves on into the
// buffer only when it is empty or its last result leaves. Decoding does not
// check hex characters; a message that ends inside an escape yields one result
// with escape_cut set and out_byte 0.
module url_percent_codec_unit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wr_en,
  input  wire logic                      cfg_wr_data,
  upc_in_if.sink                         in,
  upc_out_if.source                      out
);
  import upc_pkg::*;

  logic             decode_mode;
  logic             hold_valid;
  logic [ByteW-1:0] hold_byte;
  logic             hold_last;
  logic             can_load;
  logic             xfer;
  logic             in_fire;
  step_t            step;

  assign xfer     = hold_valid && can_load;
  assign in.ready = !hold_valid || can_load;
  assign in_fire  = in.valid && in.ready;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      decode_mode <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_fire) begin
      hold_valid <= 1'b1;
    end else if (xfer) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_byte <= in.in_byte;
      hold_last <= in.message_last;
    end
  end

  upc_step u_step (
    .clk         (clk),
    .rst         (rst),
    .fire        (xfer),
    .decode_mode (decode_mode),
    .cur_byte    (hold_byte),
    .cur_last    (hold_last),
    .step        (step)
  );

  upc_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .load     (xfer),
    .step     (step),
    .can_load (can_load),
    .out      (out)
  );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import upc_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 8;
  localparam int RandomItems = 80;

  // predicts the result bytes of the codec and checks them in order
  class url_codec_board;
    bit             decode_mode;
    phase_t         esc_phase;
    logic [3:0]     high_nib;
    res_t           expected_q[$];
    int             errors;

    function new();
      decode_mode = 1'b0;
      esc_phase   = PH_NONE;
      high_nib    = 4'h0;
      errors      = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // uppercase hex character of one nibble
    function logic [7:0] hex_char(logic [3:0] n);
      return (n > 4'd9) ? ({4'h0, n} + 8'd55) : ({4'h0, n} + 8'd48);
    endfunction

    // escape character to digit, letters of either case count from ten
    function logic [7:0] digit_of(logic [7:0] c);
      if (c >= ChUpperA && c <= ChUpperZ) begin
        return c - ChUpperA + 8'd10;
      end else if (c >= ChLowerA && c <= ChLowerZ) begin
        return c - ChLowerA + 8'd10;
      end
      return c - ChZero;
    endfunction

    function bit is_unreserved(logic [7:0] c);
      return (c >= ChUpperA && c <= ChUpperZ) || (c >= ChLowerA && c <= ChLowerZ) ||
             (c >= ChZero && c <= ChNine) || c == ChMinus || c == ChUnder ||
             c == ChDot || c == ChTilde;
    endfunction

    function void add_byte(logic [7:0] b, logic rl, logic me, logic cut);
      res_t r;
      r.out_byte    = b;
      r.run_last    = rl;
      r.message_end = me;
      r.escape_cut  = cut;
      expected_q = {expected_q, r};
    endfunction

    // accepted input beat: advance the escape state and queue its results
    function void take_in_beat(logic [7:0] b, logic last);
      logic [7:0] d;
      if (!decode_mode) begin
        esc_phase = PH_NONE;
        high_nib  = 4'h0;
        if (is_unreserved(b)) begin
          add_byte(b, 1'b1, last, 1'b0);
        end else if (b == ChSpace) begin
          add_byte(ChPlus, 1'b1, last, 1'b0);
        end else begin
          add_byte(ChPercent, 1'b0, 1'b0, 1'b0);
          add_byte(hex_char(b[7:4]), 1'b0, 1'b0, 1'b0);
          add_byte(hex_char(b[3:0]), 1'b1, last, 1'b0);
        end
      end else if (esc_phase == PH_HIGH) begin
        // message ends on the high digit, which cuts the escape
        if (last) begin
          esc_phase = PH_NONE;
          high_nib  = 4'h0;
          add_byte(8'h00, 1'b1, 1'b1, 1'b1);
        end else begin
          d         = digit_of(b);
          high_nib  = d[3:0];
          esc_phase = PH_LOW;
        end
      end else if (esc_phase == PH_LOW) begin
        d         = {high_nib, 4'h0} + digit_of(b);
        esc_phase = PH_NONE;
        high_nib  = 4'h0;
        add_byte(d, 1'b1, last, 1'b0);
      end else begin
        esc_phase = PH_NONE;
        if (b == ChPercent) begin
          if (last) begin
            high_nib = 4'h0;
            add_byte(8'h00, 1'b1, 1'b1, 1'b1);
          end else begin
            esc_phase = PH_HIGH;
          end
        end else if (b == ChPlus) begin
          add_byte(ChSpace, 1'b1, last, 1'b0);
        end else begin
          add_byte(b, 1'b1, last, 1'b0);
        end
      end
    endfunction

    // accepted result beat against the oldest expectation
    function void check_out_beat(res_t got);
      res_t exp_r;
      if (expected_q.size() == 0) begin
        $error("unexpected result beat: out_byte %02h", got.out_byte);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.out_byte !== exp_r.out_byte) begin
        $error("out_byte: expected %02h, got %02h", exp_r.out_byte, got.out_byte);
        errors++;
      end
      if (got.run_last !== exp_r.run_last) begin
        $error("run_last: expected %0b, got %0b", exp_r.run_last, got.run_last);
        errors++;
      end
      if (got.message_end !== exp_r.message_end) begin
        $error("message_end: expected %0b, got %0b", exp_r.message_end, got.message_end);
        errors++;
      end
      if (got.escape_cut !== exp_r.escape_cut) begin
        $error("escape_cut: expected %0b, got %0b", exp_r.escape_cut, got.escape_cut);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;
  bit   in_calm;
  bit   out_calm;
  int   cycle_count;

  url_codec_board board = new();

  upc_in_if  in_ch();
  upc_out_if out_ch();

  url_percent_codec_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in          (in_ch),
    .out         (out_ch)
  );

  always #6 clk = ~clk;

  // one input beat, after a random gap
  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.in_byte      <= b;
    in_ch.message_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.take_in_beat(b, last);
  endtask

  task automatic send_text(string s, bit end_msg);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], end_msg && (i == s.len() - 1));
    end
  endtask

  // stop driving and let every expected beat come out
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_mode(bit m);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    board.decode_mode = m;
  endtask

  function automatic logic [7:0] unreserved_rand();
    string set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_.~";
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  // mostly hex digits of either case, now and then any byte
  function automatic logic [7:0] escape_char_rand();
    logic [7:0] n;
    if ($urandom_range(0, 7) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    n = 8'($urandom_range(0, 15));
    if (n < 8'd10) begin
      return ChZero + n;
    end
    return ($urandom_range(0, 1) != 0) ? ChUpperA + n - 8'd10 : ChLowerA + n - 8'd10;
  endfunction

  // one random message, shaped for the current mode
  task automatic random_message(inout int sent);
    logic [7:0] msg_q[$];
    int         target;
    int         pick;
    target  = $urandom_range(1, 10);
    in_calm = ($urandom_range(0, 3) == 0);
    while (msg_q.size() < target) begin
      pick = $urandom_range(0, 99);
      if (board.decode_mode) begin
        if (pick < 45) begin
          msg_q = {msg_q, ChPercent};
          msg_q = {msg_q, escape_char_rand()};
          msg_q = {msg_q, escape_char_rand()};
        end else if (pick < 55) begin
          msg_q = {msg_q, ChPlus};
        end else if (pick < 75) begin
          msg_q = {msg_q, unreserved_rand()};
        end else if (pick < 90) begin
          msg_q = {msg_q, 8'($urandom_range(0, 255))};
        end else begin
          // escape broken off by the end of the message
          msg_q = {msg_q, ChPercent};
          if ($urandom_range(0, 1) != 0) msg_q = {msg_q, escape_char_rand()};
          break;
        end
      end else begin
        if (pick < 40) begin
          msg_q = {msg_q, unreserved_rand()};
        end else if (pick < 55) begin
          msg_q = {msg_q, ChSpace};
        end else begin
          msg_q = {msg_q, 8'($urandom_range(0, 255))};
        end
      end
    end
    foreach (msg_q[i]) send_byte(msg_q[i], i == msg_q.size() - 1);
    sent += msg_q.size();
  endtask

  // result side: random stalls with calm stretches
  initial begin
    int   stall;
    res_t got;
    out_ch.ready = 1'b0;
    out_calm     = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
      stall = out_calm ? 0 : $urandom_range(0, 5);
      @(negedge clk);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got.out_byte    = out_ch.out_byte;
      got.run_last    = out_ch.run_last;
      got.message_end = out_ch.message_end;
      got.escape_cut  = out_ch.escape_cut;
      board.check_out_beat(got);
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("url_percent_codec_unit: mismatch");
    $finish;
  end

  initial begin
    int sent;
    rst                = 1'b1;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.in_byte      = 8'h00;
    in_ch.message_last = 1'b0;
    in_calm            = 1'b0;
    sent               = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // encode after reset: byte extremes, unreserved set, space, escaped byte
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("Az09-_.~ %", 1'b1);

    // decode: plus, a digit escape, an escape of non-hex letters, cut after percent and after high digit
    write_mode(1'b1);
    send_text("+%41%zz", 1'b1);
    send_text("%", 1'b1);
    send_text("%4", 1'b1);

    // mode write while an escape is pending keeps the escape
    send_byte(ChPercent, 1'b0);
    write_mode(1'b1);
    send_text("7e", 1'b1);

    // switching to encode drops a pending escape
    send_text("%4", 1'b0);
    write_mode(1'b0);
    send_text("A", 1'b1);

    // random messages over alternating modes
    for (int p = 0; sent < RandomItems; p++) begin
      write_mode(p % 2 == 0);
      for (int n = 0; n < 6 && sent < RandomItems; n++) random_message(sent);
    end

    wait_drained();
    if (board.errors == 0) begin
      $display("url_percent_codec_unit: match");
    end else begin
      $display("url_percent_codec_unit: mismatch");
    end
    $finish;
  end

endmodule

@@ url_percent_codec_unit.f @@
rtl/upc_pkg.sv
rtl/upc_stream_if.sv
rtl/upc_step.sv
rtl/upc_outbuf.sv
rtl/url_percent_codec_unit.sv
tb/testbench.sv
